/* design/skf_pkg.sv */
// Shared types and constants for the scalar Kalman filter.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

    localparam int GAIN_BITS = 16;
    localparam int EST_BITS  = 32;
    localparam int VAR_BITS  = 32;
    localparam int OUT_W     = 48;   // estimate + gain, already whole bytes

    // 17 quotient bits (gain may reach 1.0 before saturation), 17 multiplier bits
    localparam int ITER_W    = 5;
    localparam logic [ITER_W-1:0] ITER_LAST = 5'd16;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PROCESS_NOISE     = 1'b0,
        CFG_MEASUREMENT_NOISE = 1'b1
    } cfg_index_t;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUM  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

/* design/scalar_kalman_filter.sv */
// One-dimensional fixed-point Kalman filter with an iterative divider and multiplier.
// Each sample passes through predict, load, 17 divide steps, 17 shift-add multiply
//   steps and update, in that order, with one sample in flight at a time.
// The pace is set by the 17-step restoring divider for the gain followed by the
//   17-step shift-add multiplier; the update step waits while the output is full.
// Reset (rst_n, async active low): estimate 0, variance 0.01, q 0.05, r 5.05, output empty.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // input stream: [SAMPLE_BITS-1:0] sample, zero padded to bytes
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // output stream: [31:0] estimate, [47:32] gain
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [skf_pkg::OUT_W-1:0]          m_axis_tdata,
    // configuration write channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  skf_pkg::cfg_index_t          cfg_index,
    input  wire  [skf_pkg::VAR_BITS-1:0]       cfg_data
);
    import skf_pkg::*;

    // magnitude of (sample*2^F - estimate) fits in MAG_W bits
    localparam int MAG_W   = ((SAMPLE_BITS + FRAC_BITS > EST_BITS) ?
                              (SAMPLE_BITS + FRAC_BITS) : EST_BITS) + 1;
    localparam int DIFF_W  = MAG_W + 1;
    localparam int SUM_W   = MAG_W + 2;
    localparam int PROD1_W = MAG_W + GAIN_BITS;
    localparam int PROD2_W = VAR_BITS + GAIN_BITS + 1;
    localparam int DEN_W   = VAR_BITS + 1;
    localparam int REM_W   = VAR_BITS + 2;

    localparam logic [VAR_BITS-1:0] Q_RESET =
        VAR_BITS'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);
    localparam logic [VAR_BITS-1:0] R_RESET =
        VAR_BITS'((64'd505 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [VAR_BITS-1:0] P_RESET =
        VAR_BITS'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

    // configuration
    logic [VAR_BITS-1:0] q_reg;
    logic [VAR_BITS-1:0] r_reg;

    // filter state
    logic signed [EST_BITS-1:0] est_reg;
    logic [VAR_BITS-1:0]        var_reg;

    // sequencer
    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   cnt_reg;

    // working registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [VAR_BITS-1:0]    p_reg;
    logic                   neg_reg;
    logic [DEN_W-1:0]       den_reg;
    logic                   den_zero_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [GAIN_BITS:0]     quot_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [GAIN_BITS:0]     gsh_reg;     // gain bits, shifted out LSB first
    logic [GAIN_BITS:0]     ish_reg;     // (1 - gain) bits, shifted out LSB first
    logic [PROD1_W-1:0]     mc1_reg;     // |diff| << i
    logic [PROD2_W-1:0]     mc2_reg;     // p << i
    logic [PROD1_W-1:0]     acc1_reg;    // |diff| * gain + rounding half
    logic [PROD2_W-1:0]     acc2_reg;    // p * (1 - gain)

    // output register
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;

    logic in_fire;
    logic out_free;

    // predict: p = sat(var + q)
    logic [VAR_BITS:0]      p_sum;
    logic [VAR_BITS-1:0]    p_sat;

    // innovation
    logic signed [DIFF_W-1:0] target_ext;
    logic signed [DIFF_W-1:0] est_ext;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;

    // divider step
    logic                   div_ge;
    logic [REM_W-1:0]       rem_sub;
    logic [GAIN_BITS:0]     quot_fin;
    logic [GAIN_BITS-1:0]   gain_fin;

    // update
    logic [MAG_W-1:0]       step;
    logic signed [SUM_W-1:0] est_w;
    logic signed [SUM_W-1:0] step_w;
    logic signed [SUM_W-1:0] est_sum;
    logic                   ovf_pos;
    logic                   ovf_neg;
    logic [EST_BITS-1:0]    est_sat;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign p_sum = {1'b0, var_reg} + {1'b0, q_reg};
    assign p_sat = p_sum[VAR_BITS] ? {VAR_BITS{1'b1}} : p_sum[VAR_BITS-1:0];

    assign target_ext = $signed({{(DIFF_W-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}},
                                 sample_reg}) <<< FRAC_BITS;
    assign est_ext    = $signed({{(DIFF_W-EST_BITS){est_reg[EST_BITS-1]}}, est_reg});
    assign diff       = target_ext - est_ext;
    assign diff_abs   = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    // restoring division step: quotient bit, then shift remainder
    assign div_ge   = (rem_reg >= {1'b0, den_reg});
    assign rem_sub  = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign quot_fin = {quot_reg[GAIN_BITS-1:0], div_ge};
    assign gain_fin = den_zero_reg     ? '0 :
                      quot_fin[GAIN_BITS] ? {GAIN_BITS{1'b1}} :
                      quot_fin[GAIN_BITS-1:0];

    // estimate update with saturation to the signed 32-bit range
    assign step    = acc1_reg[PROD1_W-1:GAIN_BITS];
    assign est_w   = $signed({{(SUM_W-EST_BITS){est_reg[EST_BITS-1]}}, est_reg});
    assign step_w  = $signed({2'b00, step});
    assign est_sum = neg_reg ? (est_w - step_w) : (est_w + step_w);
    assign ovf_pos = !est_sum[SUM_W-1] && (|est_sum[SUM_W-2:EST_BITS-1]);
    assign ovf_neg =  est_sum[SUM_W-1] && !(&est_sum[SUM_W-2:EST_BITS-1]);
    assign est_sat = ovf_pos ? {1'b0, {(EST_BITS-1){1'b1}}} :
                     ovf_neg ? {1'b1, {(EST_BITS-1){1'b0}}} :
                     est_sum[EST_BITS-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_SUM;
            ST_SUM:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == ITER_LAST) state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == ITER_LAST) state_next = ST_UPD;
            ST_UPD:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            q_reg         <= Q_RESET;
            r_reg         <= R_RESET;
            est_reg       <= '0;
            var_reg       <= P_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROCESS_NOISE:     q_reg <= cfg_data;
                    CFG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                    default:               q_reg <= q_reg;
                endcase
            end

            if (state_reg == ST_DIV || state_reg == ST_MUL)
                cnt_reg <= (cnt_reg == ITER_LAST) ? '0 : cnt_reg + ITER_W'(1);
            else
                cnt_reg <= '0;

            if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_UPD && out_free)
            begin
                est_reg       <= est_sat;
                var_reg       <= acc2_reg[PROD2_W-2:GAIN_BITS];
                out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];

        case (state_reg)
            ST_SUM:
            begin
                p_reg   <= p_sat;
                neg_reg <= diff[DIFF_W-1];
                mc1_reg <= PROD1_W'(diff_abs[MAG_W-1:0]);
            end
            ST_LOAD:
            begin
                den_reg      <= {1'b0, p_reg} + {1'b0, r_reg};
                den_zero_reg <= (p_reg == '0) && (r_reg == '0);
                rem_reg      <= REM_W'(p_reg);
                quot_reg     <= '0;
                mc2_reg      <= PROD2_W'(p_reg);
                acc1_reg     <= PROD1_W'(1) << (GAIN_BITS - 1);
                acc2_reg     <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= {rem_sub[REM_W-2:0], 1'b0};
                quot_reg <= quot_fin;
                if (cnt_reg == ITER_LAST)
                begin
                    gain_reg <= gain_fin;
                    gsh_reg  <= {1'b0, gain_fin};
                    ish_reg  <= ((GAIN_BITS+1)'(1) << GAIN_BITS) - {1'b0, gain_fin};
                end
            end
            ST_MUL:
            begin
                if (gsh_reg[0]) acc1_reg <= acc1_reg + mc1_reg;
                if (ish_reg[0]) acc2_reg <= acc2_reg + mc2_reg;
                mc1_reg <= mc1_reg << 1;
                mc2_reg <= mc2_reg << 1;
                gsh_reg <= gsh_reg >> 1;
                ish_reg <= ish_reg >> 1;
            end
            ST_UPD:
            begin
                if (out_free)
                    out_data_reg <= {gain_reg, est_sat};
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_SUM)
        else $error("accepted sample did not start a step");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_MUL) |-> cnt_reg <= ITER_LAST)
        else $error("iteration counter out of range");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result appeared outside the update step");

    a_variance_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && out_free) |=> var_reg <= $past(p_reg))
        else $error("updated variance exceeds predicted variance");

endmodule

`default_nettype wire
